[rtl/aes128_block_encrypt_top_assert.svh]
// Assertion macros for the AES-128 block encryption top level.
// Included by aes128_block_encrypt_top.sv; no other dependencies.
`ifndef AES128_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_TOP_ASSERT_SVH

// Assert that a condition implies a consequence in the same cycle.
`define AES_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define AES_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

[rtl/aes_pkg.sv]
// AES-128 package: S-box, GF(2^8) helpers, round functions and key schedule step.
// No dependencies; used by aes128_block_encrypt_top and aes_round.
`timescale 1ns / 1ps

package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned StageCnt = NumRounds + 1;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   byte_t;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constants for rounds 1..10; index 0 is unused.
  localparam byte_t RCON [StageCnt] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a block sits in bits 127-8i down to 120-8i.
  function automatic byte_t get_byte(input blk_t b, input int unsigned i);
    get_byte = b[127 - 8 * i -: 8];
  endfunction

  function automatic byte_t gf_double(input byte_t v);
    gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t sub_shift(input blk_t s);
    blk_t o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (c * 4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    sub_shift = o;
  endfunction

  function automatic blk_t mix_columns(input blk_t s);
    blk_t  o;
    byte_t a0, a1, a2, a3, al;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c * 4);
      a1 = get_byte(s, c * 4 + 1);
      a2 = get_byte(s, c * 4 + 2);
      a3 = get_byte(s, c * 4 + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      o[127 - 8 * (c * 4)     -: 8] = a0 ^ al ^ gf_double(a0 ^ a1);
      o[127 - 8 * (c * 4 + 1) -: 8] = a1 ^ al ^ gf_double(a1 ^ a2);
      o[127 - 8 * (c * 4 + 2) -: 8] = a2 ^ al ^ gf_double(a2 ^ a3);
      o[127 - 8 * (c * 4 + 3) -: 8] = a3 ^ al ^ gf_double(a3 ^ a0);
    end
    mix_columns = o;
  endfunction

  // One step of the key schedule: next round key from the previous one.
  function automatic blk_t next_key(input blk_t k, input byte_t rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

[rtl/aes_stream_if.sv]
// Valid/ready stream interface carrying a 128-bit block as two 64-bit halves.
// No dependencies.
`timescale 1ns / 1ps

interface aes_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;

  modport source (output valid, output data_high, output data_low, input ready);
  modport sink (input valid, input data_high, input data_low, output ready);
endinterface

[rtl/aes_cfg_if.sv]
// Configuration write channel: register index and 64-bit write data.
// No dependencies.
`timescale 1ns / 1ps

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/aes128_block_encrypt_top.sv]
// AES-128 encryption top level: key registers, entry stage, ten round stages.
// Depends on aes_pkg, aes_stream_if, aes_cfg_if, aes_round and the assert header.
`timescale 1ns / 1ps

// Usage: the key is written over the cfg channel, index 0 for key bytes 0..7
// and index 1 for bytes 8..15; a write is one transfer and cfg is always ready.
// Writes must happen only while no block is in flight. Plaintext blocks enter on
// the in channel, byte 0 in the top bits of data_high; ciphertext leaves on out.
// The pipeline has eleven register stages: an entry stage doing the initial
// AddRoundKey and one stage per round, each holding one S-box layer for the
// state and one for the key schedule. A block passes the entry register and
// then each round register in order before out valid. Throughput is one block
// per cycle while the receiver does not stall. The round keys travel alongside
// each block, so no key storage beyond the two key registers is needed.
// Reset clears the key to zero and empties the pipeline. When the receiver
// stalls, the whole pipeline holds; in_ready stays high while the last stage is
// empty or being taken, so bubbles are squeezed out only at the output.
module aes128_block_encrypt_top (
  input logic clk,
  input logic rst_n,
  aes_stream_if.sink   in_ch,
  aes_stream_if.source out_ch,
  aes_cfg_if.sink      cfg_ch
);
  import aes_pkg::*;

  logic [63:0] key_high_r, key_low_r;
  logic        en;
  logic        v0_r;
  blk_t        s0_r, k0_r;
  logic        vld [StageCnt];
  blk_t        st  [StageCnt];
  blk_t        key [StageCnt];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_KEY_HIGH: key_high_r <= cfg_ch.data;
        CFG_KEY_LOW:  key_low_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a finished block waits at the output.
  assign en = !vld[StageCnt - 1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= {in_ch.data_high, in_ch.data_low} ^ {key_high_r, key_low_r};
      k0_r <= {key_high_r, key_low_r};
    end
  end

  assign vld[0] = v0_r;
  assign st[0]  = s0_r;
  assign key[0] = k0_r;

  for (genvar g = 1; g < StageCnt; g++) begin : g_rnd
    aes_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .final_rnd (g == StageCnt - 1),
      .rc        (RCON[g]),
      .vld_in    (vld[g - 1]),
      .st_in     (st[g - 1]),
      .key_in    (key[g - 1]),
      .vld_out   (vld[g]),
      .st_out    (st[g]),
      .key_out   (key[g])
    );
  end

  assign out_ch.valid     = vld[StageCnt - 1];
  assign out_ch.data_high = st[StageCnt - 1][127:64];
  assign out_ch.data_low  = st[StageCnt - 1][63:0];

`include "aes128_block_encrypt_top_assert.svh"

  // A stalled result must not change.
  `AES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
                   out_ch.valid && $stable(out_ch.data_high), "output changed under stall")
  // Input is refused only while a result waits.
  `AES_ASSERT_IMP(a_in_ready, clk, rst_n, !in_ch.ready, out_ch.valid && !out_ch.ready,
                  "input blocked without output stall")
  // An accepted block leaves the entry stage valid.
  `AES_ASSERT_NEXT(a_entry, clk, rst_n, in_ch.valid && in_ch.ready, v0_r,
                   "accepted block lost at entry")
endmodule

[rtl/aes_round.sv]
// One pipelined AES round stage: round function plus on-the-fly key step.
// Depends on aes_pkg.
`timescale 1ns / 1ps

module aes_round (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          final_rnd,
  input  aes_pkg::byte_t rc,
  input  logic          vld_in,
  input  aes_pkg::blk_t st_in,
  input  aes_pkg::blk_t key_in,
  output logic          vld_out,
  output aes_pkg::blk_t st_out,
  output aes_pkg::blk_t key_out
);
  import aes_pkg::*;

  blk_t rk_nxt, ss_nxt, st_nxt;
  logic vld_r;
  blk_t st_r, key_r;

  always_comb begin
    rk_nxt = next_key(key_in, rc);
    ss_nxt = sub_shift(st_in);
    st_nxt = (final_rnd ? ss_nxt : mix_columns(ss_nxt)) ^ rk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r  <= st_nxt;
      key_r <= rk_nxt;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
  assign key_out = key_r;
endmodule
